### design/ccfr_pkg.sv
`default_nettype none
package ccfr_pkg;

    // Frame limits
    localparam int MAX_FRAME_BYTES = 8192;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int IDX_W           = 13;
    localparam int DLEN_W          = 14;
    localparam int MIN_FRAME       = 7;
    localparam int HDR_BYTES       = 3;
    localparam int TRAILER_BYTES   = 4;

    // COBS and CRC constants
    localparam logic [7:0]  DELIM     = 8'h00;
    localparam logic [7:0]  CODE_MAX  = 8'hFF;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOR   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    // End-of-frame status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_CRC      = 3'd2;
    localparam logic [2:0] ST_LENGTH   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // One result word
    typedef struct packed {
        logic              kind;
        logic [7:0]        data_byte;
        logic [IDX_W-1:0]  byte_index;
        logic [2:0]        status;
        logic [7:0]        command;
        logic [15:0]       header_length;
        logic [DLEN_W-1:0] decoded_length;
    } t_result;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### design/ccfr_in_stage.sv
`default_nettype none
module ccfr_in_stage
    import ccfr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [7:0] i_byte,
    input  wire        i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;

    // Slot frees up when its word moves on
    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule
`default_nettype wire

### design/ccfr_frame_core.sv
`default_nettype none
module ccfr_frame_core
    import ccfr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_fire,
    input  wire  [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [CNT_W-1:0] r_raw,  n_raw;
    logic [CNT_W-1:0] r_dec,  n_dec;
    logic [7:0]       r_grp,  n_grp;
    logic [7:0]       r_prev, n_prev;
    logic [7:0]       r_td [TRAILER_BYTES];
    logic [7:0]       n_td [TRAILER_BYTES];
    logic [31:0]      r_crc,  n_crc;
    logic [7:0]       r_cmd,  n_cmd;
    logic [15:0]      r_len,  n_len;

    logic             push;
    logic [7:0]       push_byte;
    logic             clear;
    logic [31:0]      rx_crc;
    logic [2:0]       eof_status;

    // Trailer as received, big-endian
    assign rx_crc = {r_td[0], r_td[1], r_td[2], r_td[3]};

    // Frame checks in priority order
    always_comb begin
        if (r_dec < CNT_W'(MIN_FRAME)) begin
            eof_status = ST_SHORT;
        end else if (rx_crc != (r_crc ^ CRC_XOR)) begin
            eof_status = ST_CRC;
        end else if ((17'(r_len) + 17'(HDR_BYTES + TRAILER_BYTES)) > 17'(r_dec)) begin
            eof_status = ST_LENGTH;
        end else begin
            eof_status = ST_OK;
        end
    end

    // COBS decode, trailer delay and CRC
    always_comb begin
        n_raw       = r_raw;
        n_dec       = r_dec;
        n_grp       = r_grp;
        n_prev      = r_prev;
        n_td        = r_td;
        n_crc       = r_crc;
        n_cmd       = r_cmd;
        n_len       = r_len;
        push        = 1'b0;
        push_byte   = DELIM;
        clear       = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_fire) begin
            if (i_byte == DELIM) begin
                // empty frame gives nothing
                if (r_raw != '0) begin
                    o_res_valid          = 1'b1;
                    o_res.kind           = KIND_EOF;
                    o_res.status         = eof_status;
                    o_res.command        = r_cmd;
                    o_res.header_length  = r_len;
                    o_res.decoded_length = DLEN_W'(r_dec);
                    clear                = 1'b1;
                end
            end else if (r_raw >= CNT_W'(MAX_FRAME_BYTES)) begin
                // raw overflow: flag and restart
                o_res_valid          = 1'b1;
                o_res.kind           = KIND_EOF;
                o_res.status         = ST_OVERFLOW;
                o_res.command        = r_cmd;
                o_res.header_length  = r_len;
                o_res.decoded_length = DLEN_W'(r_dec);
                clear                = 1'b1;
            end else if (r_grp == 8'd0) begin
                // code byte; implied zero after a short group
                if ((r_raw != '0) && (r_prev != CODE_MAX)) begin
                    push = 1'b1;
                end
                n_prev = i_byte;
                n_grp  = i_byte - 8'd1;
                n_raw  = r_raw + CNT_W'(1);
            end else begin
                push      = 1'b1;
                push_byte = i_byte;
                n_grp     = r_grp - 8'd1;
                n_raw     = r_raw + CNT_W'(1);
            end

            // decoded byte into header holds and trailer delay
            if (push && (r_dec < CNT_W'(MAX_FRAME_BYTES))) begin
                if (r_dec == CNT_W'(0)) begin
                    n_cmd = push_byte;
                end else if (r_dec == CNT_W'(1)) begin
                    n_len[15:8] = push_byte;
                end else if (r_dec == CNT_W'(2)) begin
                    n_len[7:0] = push_byte;
                end
                if (r_dec >= CNT_W'(TRAILER_BYTES)) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_DATA;
                    o_res.data_byte  = r_td[0];
                    o_res.byte_index = IDX_W'(r_dec - CNT_W'(TRAILER_BYTES));
                    n_crc            = crc_byte(r_crc, r_td[0]);
                end
                for (int i = 0; i < TRAILER_BYTES - 1; i++) begin
                    n_td[i] = r_td[i+1];
                end
                n_td[TRAILER_BYTES-1] = push_byte;
                n_dec = r_dec + CNT_W'(1);
            end

            if (clear) begin
                n_raw  = '0;
                n_dec  = '0;
                n_grp  = 8'd0;
                n_prev = 8'd0;
                for (int i = 0; i < TRAILER_BYTES; i++) begin
                    n_td[i] = 8'd0;
                end
                n_crc  = CRC_INIT;
                n_cmd  = 8'd0;
                n_len  = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw  <= '0;
            r_dec  <= '0;
            r_grp  <= 8'd0;
            r_prev <= 8'd0;
            for (int i = 0; i < TRAILER_BYTES; i++) begin
                r_td[i] <= 8'd0;
            end
            r_crc  <= CRC_INIT;
            r_cmd  <= 8'd0;
            r_len  <= 16'd0;
        end else begin
            r_raw  <= n_raw;
            r_dec  <= n_dec;
            r_grp  <= n_grp;
            r_prev <= n_prev;
            r_td   <= n_td;
            r_crc  <= n_crc;
            r_cmd  <= n_cmd;
            r_len  <= n_len;
        end
    end

endmodule
`default_nettype wire

### design/ccfr_out_stage.sv
`default_nettype none
module ccfr_out_stage
    import ccfr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_word_valid,
    input  wire         i_res_valid,
    input  t_result     i_res,
    output logic        o_advance,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [63:0] o_data,
    output logic [0:0]  o_user
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Input word moves on when the result slot is free or draining
    assign o_advance = i_word_valid && (!r_valid || i_ready);

    always_comb begin
        if (o_advance) begin
            n_valid = i_res_valid;
        end else begin
            n_valid = r_valid && !i_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

    // Pack fields, lowest first
    assign o_valid = r_valid;
    assign o_user  = r_res.kind;
    assign o_data  = {2'b00, r_res.decoded_length, r_res.header_length, r_res.command,
                      r_res.status, r_res.byte_index, r_res.data_byte};

endmodule
`default_nettype wire

### design/cobs_crc32_frame_receiver.sv
`default_nettype none
// COBS frame receiver with CRC-32 check.
// Slave stream carries raw link bytes, one per word; a zero byte ends a frame.
// Master stream carries one result word per decoded payload byte (tuser 0)
// and one end-of-frame word (tuser 1) with status, command byte, header
// length and decoded length. The last four decoded bytes (the big-endian
// CRC-32 trailer) are held back and never sent as payload.
// A result word passes the input register, then the result register.
// Throughput: 1 byte per cycle while the master side does not stall, set
// by the bytewise CRC-32 network and the COBS group counter, both updated
// between the two registers. Bytes that yield no result (code bytes with
// no implied zero, the delimiter of an empty frame, the first four decoded
// bytes of a frame) still pass at the same rate.
// Reset (synchronous, active low) empties both registers and starts a new
// frame expecting a code byte. When the master side stalls, the result
// register holds and one more raw byte waits in the input register; then
// s_axis_tready drops until the result word is taken.
module cobs_crc32_frame_receiver
    import ccfr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] data_byte, [20:8] byte_index,
                                        // [23:21] status, [31:24] command,
                                        // [47:32] header_length,
                                        // [61:48] decoded_length, [63:62] zero
    output logic [0:0]  m_axis_tuser    // [0] kind
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       advance;
    logic       res_valid;
    t_result    res;

    ccfr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    ccfr_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ccfr_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (in_valid),
        .i_res_valid  (res_valid),
        .i_res        (res),
        .o_advance    (advance),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_user       (m_axis_tuser)
    );

    // A taken byte lands in the input register
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> in_valid)
        else $error("accepted byte not held in input register");

    // A new result only comes from a byte that was waiting
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(in_valid))
        else $error("result word without a source byte");

    // Good frame is long enough and covers its header length
    a_ok_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && (m_axis_tdata[23:21] == ST_OK) |->
        (m_axis_tdata[61:48] >= DLEN_W'(MIN_FRAME)) &&
        ((17'(m_axis_tdata[47:32]) + 17'(HDR_BYTES + TRAILER_BYTES)) <=
         17'(m_axis_tdata[61:48])))
        else $error("ok status on a frame that fails length checks");

    // Too-short status matches the decoded length
    a_short_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && (m_axis_tdata[23:21] == ST_SHORT) |->
        (m_axis_tdata[61:48] < DLEN_W'(MIN_FRAME)))
        else $error("too-short status on a long frame");

endmodule
`default_nettype wire

### sim/ccfr_frame_watch.sv
// Shared helpers for the frame receiver bench
package ccfr_tb_pkg;

    typedef logic [7:0] t_byte_q[$];

    // Reflected CRC-32, fed one data bit at a time, LSB first
    function automatic logic [31:0] crc32_next(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            r = (r[0] ^ b[i]) ? ((r >> 1) ^ ccfr_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// Watches both streams, tracks the frame decode on its own and checks every
// result word against the oldest expected one.
module ccfr_frame_watch
    import ccfr_pkg::*;
    import ccfr_tb_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [7:0]  i_s_tdata,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [63:0] i_m_tdata,
    input  wire  [0:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending
);

    // Frame decode state
    int unsigned raw_cnt;
    int unsigned dec_cnt;
    logic [7:0]  grp_left;
    logic [7:0]  last_code;
    logic [7:0]  cmd_hold;
    logic [15:0] len_hold;
    logic [7:0]  fcs_line [4];
    logic [31:0] crc_acc;

    t_result pending_words[$];
    int      fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function void frame_restart();
        raw_cnt   = 0;
        dec_cnt   = 0;
        grp_left  = 8'h00;
        last_code = 8'h00;
        cmd_hold  = 8'h00;
        len_hold  = 16'h0000;
        crc_acc   = CRC_INIT;
        for (int i = 0; i < 4; i++) begin
            fcs_line[i] = 8'h00;
        end
    endfunction

    function void queue_eof(input logic [2:0] st);
        t_result w;
        w                = '0;
        w.kind           = KIND_EOF;
        w.status         = st;
        w.command        = cmd_hold;
        w.header_length  = len_hold;
        w.decoded_length = dec_cnt[DLEN_W-1:0];
        pending_words.push_back(w);
    endfunction

    // One decoded byte enters the trailer delay line; the oldest leaves as payload
    function void take_decoded(input logic [7:0] b);
        t_result w;
        if (dec_cnt >= MAX_FRAME_BYTES) begin
            return;
        end
        case (dec_cnt)
            0: cmd_hold = b;
            1: len_hold[15:8] = b;
            2: len_hold[7:0] = b;
            default: ;
        endcase
        if (dec_cnt >= TRAILER_BYTES) begin
            crc_acc      = crc32_next(crc_acc, fcs_line[0]);
            w            = '0;
            w.kind       = KIND_DATA;
            w.data_byte  = fcs_line[0];
            w.byte_index = IDX_W'(dec_cnt - TRAILER_BYTES);
            pending_words.push_back(w);
        end
        fcs_line[0] = fcs_line[1];
        fcs_line[1] = fcs_line[2];
        fcs_line[2] = fcs_line[3];
        fcs_line[3] = b;
        dec_cnt++;
    endfunction

    function void decode_link_byte(input logic [7:0] b);
        logic [31:0] fcs_rx;
        logic [2:0]  st;
        if (b == DELIM) begin
            // empty frames are dropped without a word
            if (raw_cnt != 0) begin
                fcs_rx = {fcs_line[0], fcs_line[1], fcs_line[2], fcs_line[3]};
                if (dec_cnt < MIN_FRAME) begin
                    st = ST_SHORT;
                end else if (fcs_rx != (crc_acc ^ CRC_XOR)) begin
                    st = ST_CRC;
                end else if (HDR_BYTES + int'(len_hold) + TRAILER_BYTES > int'(dec_cnt)) begin
                    st = ST_LENGTH;
                end else begin
                    st = ST_OK;
                end
                queue_eof(st);
                frame_restart();
            end
        end else if (raw_cnt >= MAX_FRAME_BYTES) begin
            // byte dropped, frame flagged and restarted
            queue_eof(ST_OVERFLOW);
            frame_restart();
        end else if (grp_left == 8'h00) begin
            // code byte; a short previous group implies a zero
            if (raw_cnt > 0 && last_code < CODE_MAX) begin
                take_decoded(8'h00);
            end
            last_code = b;
            grp_left  = b - 8'd1;
            raw_cnt++;
        end else begin
            grp_left--;
            raw_cnt++;
            take_decoded(b);
        end
    endfunction

    function void check_field(input string name, input int unsigned want,
                              input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    function void check_word();
        t_result want;
        if (pending_words.size() == 0) begin
            $error("result word with nothing expected: tuser %0d tdata %h",
                   i_m_tuser, i_m_tdata);
            fails++;
            return;
        end
        want = pending_words.pop_front();
        check_field("kind",           want.kind,           i_m_tuser[0]);
        check_field("data_byte",      want.data_byte,      i_m_tdata[7:0]);
        check_field("byte_index",     want.byte_index,     i_m_tdata[20:8]);
        check_field("status",         want.status,         i_m_tdata[23:21]);
        check_field("command",        want.command,        i_m_tdata[31:24]);
        check_field("header_length",  want.header_length,  i_m_tdata[47:32]);
        check_field("decoded_length", want.decoded_length, i_m_tdata[61:48]);
        check_field("pad",            0,                   i_m_tdata[63:62]);
    endfunction

    // Compare taken result words, then track the taken link byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_restart();
            pending_words.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_word();
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_link_byte(i_s_tdata);
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_words.size();
    end

endmodule

### sim/cobs_crc32_frame_receiver_tb.sv
module cobs_crc32_frame_receiver_tb;
    import ccfr_pkg::*;
    import ccfr_tb_pkg::*;

    localparam int LIMIT       = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 900;
    localparam int TAIL_ITEMS  = 150;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [63:0] m_axis_tdata;
    wire  [0:0]  m_axis_tuser;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int sent_items  = 0;
    bit idle_on     = 1'b1;
    bit calm        = 1'b0;
    bit hold_ask    = 1'b0;

    cobs_crc32_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ccfr_frame_watch u_watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random ready bursts, plus one long hold-off on request
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_ask) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_ask = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Standard COBS encoding of one decoded frame, delimiter not included
    function automatic t_byte_q cobs_pack(input t_byte_q dec);
        t_byte_q    enc;
        int         code_at;
        logic [7:0] run;
        code_at = 0;
        enc.push_back(8'h00);
        run = 8'h01;
        foreach (dec[i]) begin
            if (dec[i] == 8'h00) begin
                enc[code_at] = run;
                code_at = enc.size();
                enc.push_back(8'h00);
                run = 8'h01;
            end else begin
                enc.push_back(dec[i]);
                run++;
                if (run == CODE_MAX) begin
                    enc[code_at] = run;
                    code_at = enc.size();
                    enc.push_back(8'h00);
                    run = 8'h01;
                end
            end
        end
        enc[code_at] = run;
        return enc;
    endfunction

    // Decoded frame: command, big-endian length, body, big-endian CRC-32
    function automatic t_byte_q frame_bytes(input logic [7:0] cmd, input logic [15:0] hlen,
                                            input int body, input int zero_pct,
                                            input bit crc_bad);
        t_byte_q     dec;
        logic [31:0] acc;
        logic [31:0] fcs;
        dec.push_back(cmd);
        dec.push_back(hlen[15:8]);
        dec.push_back(hlen[7:0]);
        repeat (body) begin
            dec.push_back(($urandom_range(0, 99) < zero_pct) ? 8'h00
                                                             : 8'($urandom_range(1, 255)));
        end
        acc = CRC_INIT;
        foreach (dec[i]) begin
            acc = crc32_next(acc, dec[i]);
        end
        fcs = acc ^ CRC_XOR;
        if (crc_bad) begin
            fcs = fcs ^ (32'd1 << $urandom_range(0, 31));
        end
        dec.push_back(fcs[31:24]);
        dec.push_back(fcs[23:16]);
        dec.push_back(fcs[15:8]);
        dec.push_back(fcs[7:0]);
        return dec;
    endfunction

    task automatic send_raw(input logic [7:0] b);
        if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
    endtask

    // Link bytes of one frame, then the delimiter
    task automatic send_link(input t_byte_q enc);
        foreach (enc[i]) begin
            send_raw(enc[i]);
        end
        send_raw(DELIM);
    endtask

    // Stop offering until every expected word has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic random_frame();
        t_byte_q    dec;
        t_byte_q    enc;
        int         pick;
        int         body;
        int         zpct;
        logic [7:0] cmd;
        calm = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 99);
        body = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 600) : $urandom_range(0, 40);
        case ($urandom_range(0, 2))
            0: zpct = 0;
            1: zpct = 8;
            default: zpct = 35;
        endcase
        cmd = 8'($urandom);
        if (pick < 70) begin
            dec = frame_bytes(cmd, 16'($urandom_range(0, body)), body, zpct, 1'b0);
        end else if (pick < 78) begin
            dec = frame_bytes(cmd, 16'($urandom_range(0, body)), body, zpct, 1'b1);
        end else if (pick < 92) begin
            dec = frame_bytes(cmd, 16'($urandom_range(body + 1, 65535)), body, zpct, 1'b0);
        end else if (pick < 96) begin
            // too short to carry a header and trailer
            repeat ($urandom_range(0, 6)) begin
                dec.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
            end
        end else begin
            // raw noise, zeros included
            repeat ($urandom_range(1, 20)) begin
                enc.push_back(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom));
            end
            send_link(enc);
            return;
        end
        enc = cobs_pack(dec);
        // some length-bad frames get cut off inside the stream
        if (pick >= 85 && pick < 92) begin
            enc = enc[0:$urandom_range(0, enc.size() - 2)];
        end
        send_link(enc);
    endtask

    initial begin
        t_byte_q dec;
        t_byte_q enc;
        int      goal;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty frame
        send_raw(DELIM);
        // smallest valid frame
        send_link(cobs_pack(frame_bytes(8'hFF, 16'h0000, 0, 0, 1'b0)));
        // one decoded zero byte, then six bytes: both too short
        dec.push_back(8'h00);
        send_link(cobs_pack(dec));
        dec.delete();
        repeat (6) dec.push_back(8'hA5);
        send_link(cobs_pack(dec));
        // CRC mismatch
        send_link(cobs_pack(frame_bytes(8'h00, 16'h0000, 2, 0, 1'b1)));
        // header length far past the frame
        send_link(cobs_pack(frame_bytes(8'h80, 16'hFFFF, 5, 0, 1'b0)));
        // header length exactly fills the body
        send_link(cobs_pack(frame_bytes(8'h7F, 16'd6, 6, 50, 1'b0)));
        // delimiter in the middle of a group
        enc = cobs_pack(frame_bytes(8'h11, 16'd3, 10, 0, 1'b0));
        send_link(enc[0:5]);
        // all-zero body
        send_link(cobs_pack(frame_bytes(8'h00, 16'h0000, 12, 100, 1'b0)));
        // a full 0xFF code group
        send_link(cobs_pack(frame_bytes(8'h42, 16'd300, 300, 0, 1'b0)));
        drain();

        // long receiver hold-off while frames keep coming
        hold_ask = 1'b1;
        repeat (4) send_link(cobs_pack(frame_bytes(8'($urandom), 16'd20, 30, 10, 1'b0)));
        drain();

        // random frames
        goal = sent_items + RAND_ITEMS;
        while (sent_items < goal) begin
            random_frame();
            if ($urandom_range(0, 29) == 0) begin
                drain();
            end
        end

        // full rate at the end
        idle_on = 1'b0;
        goal = sent_items + TAIL_ITEMS;
        while (sent_items < goal) begin
            random_frame();
        end
        drain();
        repeat (16) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
